// ===== hw/rtl/lrufr_pkg.sv =====
// Shared types and codes for the LRU frame replacer.
// Item structs for both channels, the cell entry and the cell command bundle.
// No dependencies.
`default_nettype none

package lrufr_pkg;

    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;

    localparam logic [1:0] OP_VICTIM = 2'd0;
    localparam logic [1:0] OP_PIN    = 2'd1;
    localparam logic [1:0] OP_UNPIN  = 2'd2;

    localparam logic [COUNT_W-1:0] NUM_FRAMES_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]         operation;
        logic [FRAME_W-1:0] frame;
    } lrufr_req_t;

    typedef struct packed {
        logic               victim_found;
        logic [FRAME_W-1:0] victim_frame;
        logic [COUNT_W-1:0] evictable_count;
    } lrufr_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } lrufr_entry_t;

    // Broadcast to every cell for the item being accepted
    typedef struct packed {
        logic               pin;    // pin request, frame in range
        logic               load;   // unpin of a frame not in the order
        logic [FRAME_W-1:0] frame;
    } lrufr_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrufr_cell.sv =====
// One slot of the recency order: holds a frame number and its valid bit.
// Shifts toward the oldest end on a removal at or before it, loads on append.
// Depends on lrufr_pkg.
`default_nettype none

module lrufr_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lrufr_pkg::lrufr_cmd_t   cmd,
    input  logic                    shift_in,
    output logic                    shift_out,
    input  logic                    prev_valid,
    input  lrufr_pkg::lrufr_entry_t next_entry,
    output lrufr_pkg::lrufr_entry_t entry,
    output logic                    match
);
    import lrufr_pkg::*;

    logic               valid_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               take;
    logic               load;

    assign match     = valid_reg && (frame_reg == cmd.frame);
    // a removal here or upstream pulls the neighbor's entry in
    assign shift_out = shift_in || (cmd.pin && match);
    assign take      = shift_out;
    // append lands in the first empty slot
    assign load      = cmd.load && !valid_reg && prev_valid;

    assign entry.valid = valid_reg;
    assign entry.frame = frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= next_entry.valid;
        end else if (load) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            frame_reg <= next_entry.frame;
        end else if (load) begin
            frame_reg <= cmd.frame;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lru_frame_replacer.sv =====
// LRU frame replacer: a row of cells holds the evictable frames, oldest in cell 0.
// The result is registered in the output register the cycle after an item is accepted.
// Throughput: one item per cycle unless m_ready stalls; the removal ripple sets the cycle.
// Reset: all frames pinned, order empty, num_frames 64; no clearing pass needed.
// Depends on lrufr_pkg and lrufr_cell.
`default_nettype none

module lru_frame_replacer #(
    parameter int NUM_FRAMES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lrufr_pkg::lrufr_req_t s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lrufr_pkg::lrufr_rsp_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [6:0]            cfg_data
);
    import lrufr_pkg::*;

    // only 64 frame numbers exist, so the order never holds more entries
    localparam int CHAIN_DEPTH = (NUM_FRAMES < 64) ? NUM_FRAMES : 64;
    localparam logic [COUNT_W-1:0] FRAME_CAP = COUNT_W'(CHAIN_DEPTH);

    logic [COUNT_W-1:0] num_frames_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               m_valid_reg;
    lrufr_rsp_t         rsp_reg;
    lrufr_rsp_t         rsp_next;

    logic               accept;
    logic               in_range;
    logic               any_match;
    lrufr_cmd_t         cmd;

    lrufr_entry_t       entry_vec [CHAIN_DEPTH];
    logic [CHAIN_DEPTH:0]   shift_vec;
    logic [CHAIN_DEPTH-1:0] match_vec;
    logic [CHAIN_DEPTH-1:0] valid_vec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = rsp_reg;

    assign in_range  = ({1'b0, s_data.frame} < num_frames_reg)
                    && ({1'b0, s_data.frame} < FRAME_CAP);
    assign any_match = |match_vec;

    assign cmd.frame = s_data.frame;
    assign cmd.pin   = accept && (s_data.operation == OP_PIN) && in_range;
    assign cmd.load  = accept && (s_data.operation == OP_UNPIN) && in_range && !any_match;

    assign shift_vec[0] = accept && (s_data.operation == OP_VICTIM) && entry_vec[0].valid;

    genvar gi;
    generate
        for (gi = 0; gi < CHAIN_DEPTH; gi++) begin : g_cell
            lrufr_entry_t next_entry;
            logic         prev_valid;

            if (gi == CHAIN_DEPTH - 1) begin : g_last
                assign next_entry = '0;
            end else begin : g_mid
                assign next_entry = entry_vec[gi+1];
            end

            if (gi == 0) begin : g_first
                assign prev_valid = 1'b1;
            end else begin : g_rest
                assign prev_valid = entry_vec[gi-1].valid;
            end

            lrufr_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .shift_in   (shift_vec[gi]),
                .shift_out  (shift_vec[gi+1]),
                .prev_valid (prev_valid),
                .next_entry (next_entry),
                .entry      (entry_vec[gi]),
                .match      (match_vec[gi])
            );

            assign valid_vec[gi] = entry_vec[gi].valid;
        end
    endgenerate

    // a removal anywhere ripples out of the last cell
    always_comb begin
        count_next = count_reg;
        if (shift_vec[CHAIN_DEPTH]) begin
            count_next = count_reg - 1'b1;
        end else if (cmd.load) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_comb begin
        rsp_next                 = '0;
        rsp_next.victim_found    = shift_vec[0];
        rsp_next.victim_frame    = shift_vec[0] ? entry_vec[0].frame : '0;
        rsp_next.evictable_count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_frames_reg <= NUM_FRAMES_RESET;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                num_frames_reg <= cfg_data;
            end
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rsp_reg <= rsp_next;
        end
    end

    // count tracks the occupied cells
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == $countones(valid_vec))
        else $error("evictable count out of step with cell row");

    // occupied cells stay packed at the oldest end
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("hole in recency order");

    // a granted victim shrinks the order by one
    a_victim_count: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_vec[0] |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("victim did not reduce count");

    // no frame appears twice in the order
    a_no_dup_append: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !any_match)
        else $error("append of a frame already in the order");

endmodule

`default_nettype wire
